// ===== rtl/asp_pkg.sv =====
// ---------------------------------------------------------------------------
// asp_pkg: shared widths and types of the box-sphere penetration pipeline
// Holds the coordinate width and the bundles that travel down the stages.
// ---------------------------------------------------------------------------
package asp_pkg;

  // Coordinate width (signed Q16.16 words) and derived widths
  localparam int unsigned CoordBits = 32;
  localparam int unsigned HalfBits  = CoordBits - 1;      // half extents, radius, |d| on a hit
  localparam int unsigned ExtBits   = CoordBits + 2;      // clamp bounds without overflow
  localparam int unsigned SqBits    = 2 * CoordBits;      // one squared axis delta
  localparam int unsigned SumBits   = SqBits + 2;         // sum of three squares
  localparam int unsigned Dist2Bits = 2 * HalfBits;       // dist2 on a hit
  localparam int unsigned SqrtRemW  = HalfBits + 2;       // square root remainder
  localparam int unsigned NumAxes   = 3;

  // Side data that rides along the square root stages
  typedef struct packed {
    logic                                hit;
    logic [NumAxes-1:0]                  sgn;
    logic [NumAxes-1:0][HalfBits-1:0]    dm;
    logic [HalfBits-1:0]                 r;
  } root_side_t;

  // Side data that rides along the divider stages
  typedef struct packed {
    logic                                hit;
    logic                                dz;
    logic [NumAxes-1:0]                  sgn;
    logic [HalfBits-1:0]                 dlen;
  } div_side_t;

endpackage

// ===== rtl/aabb_sphere_penetration.sv =====
// ---------------------------------------------------------------------------
// aabb_sphere_penetration: box-sphere hit test with penetration vector
// Fully pipelined; clamp, squares, bit-serial square root, bit-serial divide.
// ---------------------------------------------------------------------------
// A request is taken on every cycle that start_i is high; busy_o stays low,
// so one box-sphere pair enters per clock. Each result appears on the result
// ports for one cycle with done_o high, in request order, after passing the
// clamp, square and sum stages, the one-bit-per-stage square root (31 stages),
// the penetration stage and the one-bit-per-stage divider (31 stages). The
// receiver cannot stall the pipeline and must take each result in the cycle
// it is shown.
module aabb_sphere_penetration (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [asp_pkg::CoordBits-1:0] box_center_x_i,
  input  logic signed [asp_pkg::CoordBits-1:0] box_center_y_i,
  input  logic signed [asp_pkg::CoordBits-1:0] box_center_z_i,
  input  logic        [asp_pkg::HalfBits-1:0]  box_half_x_i,
  input  logic        [asp_pkg::HalfBits-1:0]  box_half_y_i,
  input  logic        [asp_pkg::HalfBits-1:0]  box_half_z_i,
  input  logic signed [asp_pkg::CoordBits-1:0] ball_center_x_i,
  input  logic signed [asp_pkg::CoordBits-1:0] ball_center_y_i,
  input  logic signed [asp_pkg::CoordBits-1:0] ball_center_z_i,
  input  logic        [asp_pkg::HalfBits-1:0]  ball_radius_i,
  output logic                                done_o,
  output logic                                hit_o,
  output logic signed [asp_pkg::CoordBits-1:0] push_x_o,
  output logic signed [asp_pkg::CoordBits-1:0] push_y_o,
  output logic signed [asp_pkg::CoordBits-1:0] push_z_o
);

  localparam int unsigned C  = asp_pkg::CoordBits;
  localparam int unsigned H  = asp_pkg::HalfBits;
  localparam int unsigned E  = asp_pkg::ExtBits;
  localparam int unsigned NA = asp_pkg::NumAxes;

  assign busy_o = 1'b0;

  // -------------------------------------------------------------------------
  // Stage A: clamp sphere center into the box, register signed delta
  // -------------------------------------------------------------------------
  logic [NA-1:0][C-1:0] cen, sph;
  logic [NA-1:0][H-1:0] half;
  logic [NA-1:0][C-1:0] dmag_a;
  logic [NA-1:0]        dsgn_a;

  assign cen  = {box_center_z_i, box_center_y_i, box_center_x_i};
  assign sph  = {ball_center_z_i, ball_center_y_i, ball_center_x_i};
  assign half = {box_half_z_i, box_half_y_i, box_half_x_i};

  always_comb begin
    logic signed [E-1:0] lo, hi, s, d;
    for (int a = 0; a < NA; a++) begin
      lo = $signed({{2{cen[a][C-1]}}, cen[a]}) - $signed({3'b000, half[a]});
      hi = $signed({{2{cen[a][C-1]}}, cen[a]}) + $signed({3'b000, half[a]});
      s  = $signed({{2{sph[a][C-1]}}, sph[a]});
      if (s < lo) begin
        d = s - lo;
      end else if (s > hi) begin
        d = s - hi;
      end else begin
        d = '0;
      end
      dsgn_a[a] = d[E-1];
      dmag_a[a] = d[E-1] ? C'(-d) : C'(d);
    end
  end

  logic                 va_q;
  logic [NA-1:0][C-1:0] dm_a_q;
  logic [NA-1:0]        sg_a_q;
  logic [H-1:0]         r_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dm_a_q <= dmag_a;
    sg_a_q <= dsgn_a;
    r_a_q  <= ball_radius_i;
  end

  // -------------------------------------------------------------------------
  // Stage B: squares of the deltas and of the radius
  // -------------------------------------------------------------------------
  logic                                   vb_q;
  logic [NA-1:0][asp_pkg::SqBits-1:0]     sq_b_q;
  logic [asp_pkg::Dist2Bits-1:0]          r2_b_q;
  logic [NA-1:0][C-1:0]                   dm_b_q;
  logic [NA-1:0]                          sg_b_q;
  logic [H-1:0]                           r_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NA; a++) begin
      sq_b_q[a] <= dm_a_q[a] * dm_a_q[a];
    end
    r2_b_q <= r_a_q * r_a_q;
    dm_b_q <= dm_a_q;
    sg_b_q <= sg_a_q;
    r_b_q  <= r_a_q;
  end

  // -------------------------------------------------------------------------
  // Stage C: sum of squares, hit compare
  // -------------------------------------------------------------------------
  logic [asp_pkg::SumBits-1:0] dist2_c;
  logic                        hit_c;

  assign dist2_c = asp_pkg::SumBits'(sq_b_q[0]) + asp_pkg::SumBits'(sq_b_q[1])
                 + asp_pkg::SumBits'(sq_b_q[2]);
  assign hit_c   = dist2_c < asp_pkg::SumBits'(r2_b_q);

  // Square root pipeline: one root bit per stage
  logic                          vs_q   [0:H];
  logic [asp_pkg::Dist2Bits-1:0] d2_s_q [0:H];
  logic [asp_pkg::SqrtRemW-1:0]  rem_s_q[0:H];
  logic [H-1:0]                  root_q [0:H];
  asp_pkg::root_side_t           side_s_q[0:H];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q[0] <= 1'b0;
    end else begin
      vs_q[0] <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_s_q[0]       <= dist2_c[asp_pkg::Dist2Bits-1:0];
    rem_s_q[0]      <= '0;
    root_q[0]       <= '0;
    side_s_q[0].hit <= hit_c;
    side_s_q[0].sgn <= sg_b_q;
    side_s_q[0].r   <= r_b_q;
    for (int a = 0; a < NA; a++) begin
      side_s_q[0].dm[a] <= dm_b_q[a][H-1:0];
    end
  end

  for (genvar j = 0; j < H; j++) begin : g_sqrt
    logic [asp_pkg::SqrtRemW-1:0] remx, trial;
    logic                         take;

    // Bring down the next bit pair and try the trial subtrahend
    assign remx  = {rem_s_q[j][asp_pkg::SqrtRemW-3:0],
                    d2_s_q[j][asp_pkg::Dist2Bits-1-2*j -: 2]};
    assign trial = {root_q[j], 2'b01};
    assign take  = remx >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[j+1] <= 1'b0;
      end else begin
        vs_q[j+1] <= vs_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      d2_s_q[j+1]   <= d2_s_q[j];
      rem_s_q[j+1]  <= take ? remx - trial : remx;
      root_q[j+1]   <= {root_q[j][H-2:0], take};
      side_s_q[j+1] <= side_s_q[j];
    end
  end

  // -------------------------------------------------------------------------
  // Stage P: penetration depth, then per-axis products
  // -------------------------------------------------------------------------
  logic                 vp_q;
  logic [H-1:0]         pen_p_q;
  logic [H-1:0]         dist_p_q;
  logic [NA-1:0][H-1:0] dm_p_q;
  logic [NA-1:0]        sg_p_q;
  logic                 hit_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= vs_q[H];
    end
  end

  always_ff @(posedge clk_i) begin
    pen_p_q  <= side_s_q[H].r - root_q[H];
    dist_p_q <= root_q[H];
    dm_p_q   <= side_s_q[H].dm;
    sg_p_q   <= side_s_q[H].sgn;
    hit_p_q  <= side_s_q[H].hit;
  end

  // Divider pipeline: one quotient bit per stage
  logic                          vd_q   [0:H];
  logic [NA-1:0][2*H-1:0]        num_q  [0:H];
  logic [NA-1:0][H-1:0]          drem_q [0:H];
  logic [NA-1:0][H-1:0]          quo_q  [0:H];
  asp_pkg::div_side_t            side_d_q[0:H];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q[0] <= 1'b0;
    end else begin
      vd_q[0] <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [2*H-1:0] prod;
    for (int a = 0; a < NA; a++) begin
      prod         = dm_p_q[a] * pen_p_q;
      num_q[0][a]  <= prod;
      // quotient stays below 2^H, so the top half is already below the divisor
      drem_q[0][a] <= prod[2*H-1:H];
      quo_q[0][a]  <= '0;
    end
    side_d_q[0].hit  <= hit_p_q;
    side_d_q[0].dz   <= dist_p_q == '0;
    side_d_q[0].sgn  <= sg_p_q;
    side_d_q[0].dlen <= dist_p_q;
  end

  for (genvar k = 0; k < H; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[k+1] <= 1'b0;
      end else begin
        vd_q[k+1] <= vd_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      logic [H:0] remx;
      for (int a = 0; a < NA; a++) begin
        remx = {drem_q[k][a], num_q[k][a][H-1-k]};
        if (remx >= {1'b0, side_d_q[k].dlen}) begin
          drem_q[k+1][a] <= H'(remx - {1'b0, side_d_q[k].dlen});
          quo_q[k+1][a]  <= {quo_q[k][a][H-2:0], 1'b1};
        end else begin
          drem_q[k+1][a] <= remx[H-1:0];
          quo_q[k+1][a]  <= {quo_q[k][a][H-2:0], 1'b0};
        end
      end
      num_q[k+1]    <= num_q[k];
      side_d_q[k+1] <= side_d_q[k];
    end
  end

  // -------------------------------------------------------------------------
  // Output: apply sign, zero for miss or center inside box
  // -------------------------------------------------------------------------
  logic                 done_q;
  logic                 hit_q;
  logic [NA-1:0][C-1:0] push_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vd_q[H];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [C-1:0] q;
    hit_q <= side_d_q[H].hit;
    for (int a = 0; a < NA; a++) begin
      q = {1'b0, quo_q[H][a]};
      if (!side_d_q[H].hit || side_d_q[H].dz) begin
        push_q[a] <= '0;
      end else if (side_d_q[H].sgn[a]) begin
        push_q[a] <= -q;
      end else begin
        push_q[a] <= q;
      end
    end
  end

  assign done_o   = done_q;
  assign hit_o    = hit_q;
  assign push_x_o = push_q[0];
  assign push_y_o = push_q[1];
  assign push_z_o = push_q[2];

endmodule
